>>> rtl/lmd_pkg.sv
// lmd_pkg: shared types, codes and constants of the light Morse decoder.
// Used by the channel interfaces and by every lmd module.
// No dependencies.
package lmd_pkg;

    // Field widths fixed by the item format
    localparam int MODE_BITS      = 2;
    localparam int CHAR_BITS      = 8;
    localparam int THRESH_BITS    = 12;
    localparam int TICK_BITS      = 8;
    localparam int BRIGHT_BITS    = 16;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 12;

    // Input item modes
    localparam logic [MODE_BITS-1:0] MODE_TICK  = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_CLEAR = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESHOLD  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DOT_MAX    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DASH_MAX   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WORD_MIN   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LETTER_GAP = 3'd4;

    // Configuration reset values
    localparam logic [THRESH_BITS-1:0] RST_THRESHOLD  = 12'd2322;
    localparam logic [TICK_BITS-1:0]   RST_DOT_MAX    = 8'd1;
    localparam logic [TICK_BITS-1:0]   RST_DASH_MAX   = 8'd4;
    localparam logic [TICK_BITS-1:0]   RST_WORD_MIN   = 8'd6;
    localparam logic [TICK_BITS-1:0]   RST_LETTER_GAP = 8'd5;

    // ASCII codes
    localparam logic [CHAR_BITS-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_BITS-1:0] CH_DASH  = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_BITS-1:0] CH_A     = 8'h41;
    localparam logic [CHAR_BITS-1:0] CH_NUL   = 8'h00;

    // Letter table A..Z: symbol count and dash map (bit i set = symbol i is a dash)
    localparam int LETTER_COUNT = 26;
    localparam int LETTER_BITS  = 5;
    localparam logic [2:0] SYM_LEN [LETTER_COUNT] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
        3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
    };
    localparam logic [3:0] SYM_BITS [LETTER_COUNT] = '{
        4'h2, 4'h1, 4'h5, 4'h1, 4'h0, 4'h4, 4'h3, 4'h0, 4'h0, 4'hE, 4'h5, 4'h2, 4'h3,
        4'h1, 4'h7, 4'h6, 4'hB, 4'h2, 4'h0, 4'h1, 4'h4, 4'h8, 4'h6, 4'h9, 4'hD, 4'h3
    };

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_ECHO = 2'd0,
        KIND_CHAR = 2'd1,
        KIND_END  = 2'd2
    } t_kind;

    // Commands for the back end
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    typedef struct packed {
        t_op                  op;
        logic                 echo_en;
        logic [CHAR_BITS-1:0] echo_char;
        logic                 app_en;
        logic [CHAR_BITS-1:0] app_char;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Back end sequencer
    typedef enum logic [1:0] {
        BK_IDLE  = 2'd0,
        BK_FETCH = 2'd1,
        BK_EMIT  = 2'd2
    } t_back_state;

endpackage

>>> rtl/lmd_if.sv
// lmd_if: valid/ready channel interfaces of the light Morse decoder.
// Depends on lmd_pkg.
interface lmd_in_if #(parameter int SAMPLE_BITS = 12);
    import lmd_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [MODE_BITS-1:0]   mode;
    logic [SAMPLE_BITS-1:0] sample;
    modport source (output valid, output mode, output sample, input ready);
    modport sink   (input valid, input mode, input sample, output ready);
endinterface

interface lmd_out_if;
    import lmd_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [1:0]           kind;
    logic [CHAR_BITS-1:0] char_code;
    logic                 last;
    modport source (output valid, output kind, output char_code, output last, input ready);
    modport sink   (input valid, input kind, input char_code, input last, output ready);
endinterface

interface lmd_cfg_if;
    import lmd_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/lmd_queue.sv
// lmd_queue: short command queue between the front and back ends.
// Depends on lmd_pkg.
module lmd_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  lmd_pkg::t_cmd      i_push_cmd,
    input  logic               i_pop,
    output lmd_pkg::t_cmd      o_head,
    output lmd_pkg::t_q_status o_status
);
    import lmd_pkg::*;

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_BITS-1:0] r_count, n_count;
    logic                w_push, w_pop;

    // Guard against push when full and pop when empty
    assign w_push = i_push && (r_count != CNT_BITS'(QUEUE_DEPTH));
    assign w_pop  = i_pop && (r_count != '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage, no reset
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CNT_BITS'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

>>> rtl/lmd_front.sv
// lmd_front: accepts items and config writes, tracks bright/dark runs and the
// symbol code, decodes letters and issues commands to the queue.
// Depends on lmd_pkg and lmd_if.
module lmd_front #(
    parameter int MAX_SYMBOLS = 4,
    parameter int SAMPLE_BITS = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    lmd_in_if.sink             i_in,
    lmd_cfg_if.sink            i_cfg,
    input  lmd_pkg::t_q_status i_q_status,
    output logic               o_push,
    output lmd_pkg::t_cmd      o_push_cmd
);
    import lmd_pkg::*;

    localparam int CMP_BITS = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;
    localparam int PAT_BITS = MAX_SYMBOLS;
    localparam int LEN_BITS = $clog2(MAX_SYMBOLS + 1);

    // Configuration registers
    logic [THRESH_BITS-1:0] r_threshold;
    logic [TICK_BITS-1:0]   r_dot_max;
    logic [TICK_BITS-1:0]   r_dash_max;
    logic [TICK_BITS-1:0]   r_word_min;
    logic [TICK_BITS-1:0]   r_letter_gap;

    // Run and code state
    logic [BRIGHT_BITS-1:0] r_bright, n_bright;
    logic [TICK_BITS-1:0]   r_dark, n_dark;
    logic [PAT_BITS-1:0]    r_pat, n_pat;
    logic [LEN_BITS-1:0]    r_len, n_len;
    logic                   r_inv, n_inv;

    logic                   w_accept;
    logic                   w_bright;
    logic [TICK_BITS-1:0]   w_dark_inc;
    logic                   w_sym_en;
    logic                   w_sym_dash;
    logic                   w_found;
    logic [LETTER_BITS-1:0] w_letter;
    t_cmd                   w_cmd;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !i_q_status.full;
    assign w_accept    = i_in.valid && !i_q_status.full;

    // Config writes; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold  <= RST_THRESHOLD;
            r_dot_max    <= RST_DOT_MAX;
            r_dash_max   <= RST_DASH_MAX;
            r_word_min   <= RST_WORD_MIN;
            r_letter_gap <= RST_LETTER_GAP;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_THRESHOLD:  r_threshold  <= i_cfg.data;
                CFG_DOT_MAX:    r_dot_max    <= i_cfg.data[TICK_BITS-1:0];
                CFG_DASH_MAX:   r_dash_max   <= i_cfg.data[TICK_BITS-1:0];
                CFG_WORD_MIN:   r_word_min   <= i_cfg.data[TICK_BITS-1:0];
                CFG_LETTER_GAP: r_letter_gap <= i_cfg.data[TICK_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Tick classification, code collection and letter decode
    always_comb begin
        n_bright   = r_bright;
        n_dark     = r_dark;
        n_pat      = r_pat;
        n_len      = r_len;
        n_inv      = r_inv;
        w_sym_en   = 1'b0;
        w_sym_dash = 1'b0;
        w_found    = 1'b0;
        w_letter   = '0;
        w_dark_inc = (r_dark == '1) ? r_dark : r_dark + 1'b1;
        w_bright   = CMP_BITS'(i_in.sample) > CMP_BITS'(r_threshold);

        w_cmd.op        = OP_TICK;
        w_cmd.echo_en   = 1'b0;
        w_cmd.echo_char = CH_DOT;
        w_cmd.app_en    = 1'b0;
        w_cmd.app_char  = CH_SPACE;

        if (w_bright) begin
            n_bright = (r_bright == '1) ? r_bright : r_bright + 1'b1;
            n_dark   = '0;
        end else begin
            // End of a bright run: dot, dash, or word space; a run between the dash and word limits gives no symbol
            if (r_bright != '0) begin
                if (r_bright <= BRIGHT_BITS'(r_dot_max)) begin
                    w_cmd.echo_en   = 1'b1;
                    w_cmd.echo_char = CH_DOT;
                    w_sym_en        = 1'b1;
                end else if (r_bright <= BRIGHT_BITS'(r_dash_max)) begin
                    w_cmd.echo_en   = 1'b1;
                    w_cmd.echo_char = CH_DASH;
                    w_sym_en        = 1'b1;
                    w_sym_dash      = 1'b1;
                end else if (r_bright >= BRIGHT_BITS'(r_word_min)) begin
                    w_cmd.echo_en   = 1'b1;
                    w_cmd.echo_char = CH_SPACE;
                    w_cmd.app_en    = 1'b1;
                    n_inv           = 1'b1;
                end
                n_bright = '0;
            end
            if (w_sym_en) begin
                if (r_len < LEN_BITS'(MAX_SYMBOLS)) begin
                    n_pat = r_pat | ({{(PAT_BITS-1){1'b0}}, w_sym_dash} << r_len);
                    n_len = r_len + 1'b1;
                end else begin
                    n_inv = 1'b1;
                end
            end
            n_dark = w_dark_inc;
            // Letter gap reached: look up the code, then start a new one
            if (w_dark_inc >= r_letter_gap) begin
                for (int i = 0; i < LETTER_COUNT; i++) begin
                    if (!w_found && n_len == LEN_BITS'(SYM_LEN[i])
                            && n_pat == PAT_BITS'(SYM_BITS[i])) begin
                        w_found  = 1'b1;
                        w_letter = LETTER_BITS'(i);
                    end
                end
                if (w_found && !n_inv && n_len != '0) begin
                    w_cmd.app_en   = 1'b1;
                    w_cmd.app_char = CH_A + CHAR_BITS'(w_letter);
                end
                n_pat  = '0;
                n_len  = '0;
                n_inv  = 1'b0;
                n_dark = '0;
            end
        end

        // Read and clear go straight to the back end
        if (i_in.mode == MODE_READ) begin
            w_cmd.op = OP_READ;
        end else if (i_in.mode == MODE_CLEAR) begin
            w_cmd.op = OP_CLEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright <= '0;
            r_dark   <= '0;
            r_pat    <= '0;
            r_len    <= '0;
            r_inv    <= 1'b0;
        end else if (w_accept && i_in.mode == MODE_TICK) begin
            r_bright <= n_bright;
            r_dark   <= n_dark;
            r_pat    <= n_pat;
            r_len    <= n_len;
            r_inv    <= n_inv;
        end
    end

    // Enqueue only items that leave work for the back end
    always_comb begin
        o_push_cmd = w_cmd;
        case (i_in.mode) inside
            MODE_TICK:               o_push = w_accept && (w_cmd.echo_en || w_cmd.app_en);
            MODE_READ, MODE_CLEAR:   o_push = w_accept;
            default:                 o_push = 1'b0;
        endcase
    end

endmodule

>>> rtl/lmd_back.sv
// lmd_back: runs queued commands: echoes, message appends, clear and the
// message read stream, with the output register.
// Depends on lmd_pkg and lmd_if.
module lmd_back #(
    parameter int MESSAGE_DEPTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  lmd_pkg::t_cmd i_cmd,
    output logic          o_pop,
    lmd_out_if.source     o_out
);
    import lmd_pkg::*;

    localparam int LEN_BITS  = $clog2(MESSAGE_DEPTH + 1);
    localparam int ADDR_BITS = (MESSAGE_DEPTH > 1) ? $clog2(MESSAGE_DEPTH) : 1;

    t_back_state          r_state, n_state;
    logic [LEN_BITS-1:0]  r_len, n_len;
    logic [LEN_BITS-1:0]  r_idx, n_idx;
    logic [CHAR_BITS-1:0] r_mem [MESSAGE_DEPTH];
    logic [CHAR_BITS-1:0] r_rd_data;
    logic                 w_we;

    logic                 r_out_valid;
    t_kind                r_kind, n_kind;
    logic [CHAR_BITS-1:0] r_char, n_char;
    logic                 r_last, n_last;
    logic                 w_load;
    logic                 w_out_free;

    assign w_out_free = !r_out_valid || o_out.ready;

    // Sequencer: next state and command handling
    always_comb begin
        n_state = r_state;
        n_len   = r_len;
        n_idx   = r_idx;
        o_pop   = 1'b0;
        w_we    = 1'b0;
        w_load  = 1'b0;
        n_kind  = KIND_ECHO;
        n_char  = i_cmd.echo_char;
        n_last  = 1'b1;
        unique case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.op)
                        OP_TICK: begin
                            if (!i_cmd.echo_en || w_out_free) begin
                                o_pop  = 1'b1;
                                w_load = i_cmd.echo_en;
                                if (i_cmd.app_en && r_len < LEN_BITS'(MESSAGE_DEPTH)) begin
                                    w_we  = 1'b1;
                                    n_len = r_len + 1'b1;
                                end
                            end
                        end
                        OP_READ: begin
                            n_idx   = '0;
                            n_state = BK_FETCH;
                        end
                        OP_CLEAR: begin
                            o_pop = 1'b1;
                            n_len = '0;
                        end
                        default: o_pop = 1'b1;
                    endcase
                end
            end
            BK_FETCH: begin
                n_state = BK_EMIT;
            end
            BK_EMIT: begin
                if (w_out_free) begin
                    w_load = 1'b1;
                    if (r_idx == r_len) begin
                        n_kind  = KIND_END;
                        n_char  = CH_NUL;
                        n_last  = 1'b1;
                        o_pop   = 1'b1;
                        n_state = BK_IDLE;
                    end else begin
                        n_kind  = KIND_CHAR;
                        n_char  = r_rd_data;
                        n_last  = 1'b0;
                        n_idx   = r_idx + 1'b1;
                        n_state = BK_FETCH;
                    end
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_len   <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_idx   <= n_idx;
        end
    end

    // Message store: write at the fill point, registered read at the stream index
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_len[ADDR_BITS-1:0]] <= i_cmd.app_char;
        end
        r_rd_data <= r_mem[r_idx[ADDR_BITS-1:0]];
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_kind <= n_kind;
            r_char <= n_char;
            r_last <= n_last;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.kind      = r_kind;
    assign o_out.char_code = r_char;
    assign o_out.last      = r_last;

endmodule

>>> rtl/light_morse_decoder.sv
// light_morse_decoder: one input item per cycle while the command queue has room.
// A tick result passes through the command queue and then the output register; a
// read item streams its stored characters, paced by the registered message store read.
// Ticks with neither echo nor append cost the back end nothing; echo ticks wait for a
// free output register, while append-only ticks and clears are taken without waiting for it.
// Reset is synchronous, active low: thresholds return to defaults, the code, the run
// counters, queue and message length clear; the store needs no clearing pass.
module light_morse_decoder #(
    parameter int MESSAGE_DEPTH = 32,
    parameter int MAX_SYMBOLS   = 4,
    parameter int SAMPLE_BITS   = 12
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lmd_in_if.sink    i_in,
    lmd_cfg_if.sink   i_cfg,
    lmd_out_if.source o_out
);
    import lmd_pkg::*;

    logic      w_push;
    t_cmd      w_push_cmd;
    logic      w_pop;
    t_cmd      w_head;
    t_q_status w_q_status;

    // Front end: classify ticks and decode letters
    lmd_front #(
        .MAX_SYMBOLS (MAX_SYMBOLS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg      (i_cfg),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_push_cmd (w_push_cmd)
    );

    // Command queue
    lmd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_cmd (w_push_cmd),
        .i_pop      (w_pop),
        .o_head     (w_head),
        .o_status   (w_q_status)
    );

    // Back end: message store and result stream
    lmd_back #(
        .MESSAGE_DEPTH (MESSAGE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!w_q_status.empty),
        .i_cmd       (w_head),
        .o_pop       (w_pop),
        .o_out       (o_out)
    );

`ifndef NO_ASSERTIONS
    // Echo and end beats close their item; message characters never do
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.last == (o_out.kind != KIND_CHAR)))
        else $error("last flag does not match result kind");

    // Echoed symbols are only dot, dash or space
    a_echo_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind == KIND_ECHO) |->
        (o_out.char_code == CH_DOT || o_out.char_code == CH_DASH
         || o_out.char_code == CH_SPACE))
        else $error("bad echo symbol");

    // Queue status is consistent
    a_queue_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_status.full && w_q_status.empty))
        else $error("queue both full and empty");

    // A push is never issued into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_status.full)
        else $error("command pushed into full queue");
`endif

endmodule
